// ===== rtl/lsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants and types for the 3x3 cross-kernel sharpening core.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W      = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int ROW_W      = 13;
   localparam int CNT_W      = 23;
   localparam int TOTAL_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int DIV_CNT_W  = $clog2(CNT_W);

   localparam logic [ROW_W-1:0]    ROW_LIMIT      = {ROW_W{1'b1}};
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH    = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT   = HEIGHT_W'(480);
   localparam logic [TOTAL_W-1:0]  RESET_TOTAL    = TOTAL_W'(640 * 480);
   localparam logic [WIDTH_W-1:0]  EFF_WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] EFF_HEIGHT_MAX = HEIGHT_W'(MAX_HEIGHT);

   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] quotient;
      logic [COL_W-1:0] remainder;
   } div_status_type;

endpackage

// ===== rtl/lsh_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_line_store
// Two line memories for the rows above the current one. Registered read,
// one write per cycle, with bypass when a read hits the column being written.
// ----------------------------------------------------------------------------
module lsh_line_store import lsh_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_upper,
   input  logic [PIX_W-1:0] wr_middle,
   output logic [PIX_W-1:0] rd_upper,
   output logic [PIX_W-1:0] rd_middle
);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [PIX_W-1:0] upper_rd_ff;
   logic [PIX_W-1:0] middle_rd_ff;
   logic [PIX_W-1:0] byp_upper_ff;
   logic [PIX_W-1:0] byp_middle_ff;
   logic             byp_ff;
   logic             byp_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         upper_rd_ff   <= upper_mem[rd_addr];
         middle_rd_ff  <= middle_mem[rd_addr];
         byp_upper_ff  <= wr_upper;
         byp_middle_ff <= wr_middle;
      end
   end

   always_comb begin
      byp_in = byp_ff;
      if (rd_en) begin
         byp_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_upper  = byp_ff ? byp_upper_ff  : upper_rd_ff;
   assign rd_middle = byp_ff ? byp_middle_ff : middle_rd_ff;

endmodule

// ===== rtl/lsh_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_divider
// Bit-serial restoring divider that splits the output word count into
// row and column after the frame width or height changes.
// ----------------------------------------------------------------------------
module lsh_divider import lsh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CNT_W-1:0]   dividend,
   input  logic [WIDTH_W-1:0] divisor,
   output div_status_type     status
);

   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_CNT_W-1:0] count_in;
   logic [CNT_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     quo_in;
   logic [WIDTH_W-1:0]   rem_ff;
   logic [WIDTH_W-1:0]   rem_in;
   logic [WIDTH_W-1:0]   shifted;
   logic                 fits;

   assign shifted = {rem_ff[WIDTH_W-2:0], quo_ff[CNT_W-1]};
   assign fits    = shifted >= divisor;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[CNT_W-2:0], fits};
         rem_in   = fits ? (shifted - divisor) : shifted;
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(CNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.busy      = busy_ff || done_ff;
   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff[COL_W-1:0];

endmodule

// ===== rtl/laplacian_sharpen_3x3_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core
// Streaming 3x3 cross-kernel sharpening filter for 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one word per clock in raster order and returns one sharpened word per
// clock while rsp_ready allows. The output lags the input by image_width+1
// words; words that fall in that lag give no output, and image_width+1 flush
// words after the frame drain it. Outputs pass the stage-one and result
// registers. Each interior output is 5*centre less its four neighbours,
// clamped to 0..255; border pixels come out as 0 and the frame's final pixel
// carries rsp_frame_last. Two 2048-entry line memories hold the previous rows.
// During each image_width or image_height write, and after it while a 23-step
// serial divider re-derives the output row and column, the core takes no word.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_core import lsh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_frame_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic [WIDTH_W-1:0]  eff_width;
   logic [HEIGHT_W-1:0] eff_height;
   logic                csr_wr_width;
   logic                csr_wr_height;

   // position counters
   logic [COL_W-1:0]   in_column_ff;
   logic [COL_W-1:0]   in_column_in;
   logic [ROW_W-1:0]   in_row_ff;
   logic [ROW_W-1:0]   in_row_in;
   logic [CNT_W-1:0]   out_count_ff;
   logic [CNT_W-1:0]   out_count_in;
   logic [COL_W-1:0]   out_col_ff;
   logic [COL_W-1:0]   out_col_in;
   logic [CNT_W-1:0]   out_row_ff;
   logic [CNT_W-1:0]   out_row_in;

   logic [COL_W-1:0]   col_cur;
   logic [WIDTH_W-1:0] col_inc;
   logic               col_wrap;
   logic [WIDTH_W-1:0] ocol_inc;
   logic               ocol_wrap;
   logic               emit;
   logic               last_hit;
   logic               interior;
   logic [PIX_W-1:0]   pixel_x;
   logic               req_accept;

   // stage one
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_emit_ff;
   logic               s1_interior_ff;
   logic               s1_last_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [PIX_W-1:0]   s1_pixel_ff;
   logic               s1_advance;
   logic [PIX_W-1:0]   top;
   logic [PIX_W-1:0]   mid;

   // window columns that the kernel still needs
   logic [PIX_W-1:0]   win_mid1_ff;
   logic [PIX_W-1:0]   win_mid2_ff;
   logic [PIX_W-1:0]   win_top2_ff;
   logic [PIX_W-1:0]   win_bot2_ff;

   logic [10:0]        centre5;
   logic [9:0]         neigh_sum;
   logic signed [11:0] sharp;
   logic [PIX_W-1:0]   sharp_clamped;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic               rsp_last_ff;

   div_status_type     div_st;

   // configuration port
   assign csr_ready     = 1'b1;
   assign csr_wr_width  = csr_valid && (csr_index == CSR_IMAGE_WIDTH);
   assign csr_wr_height = csr_valid && (csr_index == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_WIDTH;
         image_height_ff <= RESET_HEIGHT;
         total_ff        <= RESET_TOTAL;
      end else begin
         if (csr_wr_width) begin
            image_width_ff <= csr_wdata[WIDTH_W-1:0];
         end
         if (csr_wr_height) begin
            image_height_ff <= csr_wdata[HEIGHT_W-1:0];
         end
         total_ff <= total_in;
      end
   end

   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (image_width_ff > EFF_WIDTH_MAX) begin
         eff_width = EFF_WIDTH_MAX;
      end else begin
         eff_width = image_width_ff;
      end
      if (image_height_ff == '0) begin
         eff_height = HEIGHT_W'(1);
      end else if (image_height_ff > EFF_HEIGHT_MAX) begin
         eff_height = EFF_HEIGHT_MAX;
      end else begin
         eff_height = image_height_ff;
      end
   end

   assign total_in = TOTAL_W'(eff_width) * TOTAL_W'(eff_height);

   lsh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_wr_width || csr_wr_height),
      .dividend (out_count_ff),
      .divisor  (eff_width),
      .status   (div_st)
   );

   // handshake
   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !div_st.busy && !csr_valid && (!s1_valid_ff || s1_advance);
   assign req_accept = req_valid && req_ready;

   // position decode
   assign col_cur   = ({1'b0, in_column_ff} >= eff_width) ? '0 : in_column_ff;
   assign col_inc   = {1'b0, col_cur} + WIDTH_W'(1);
   assign col_wrap  = col_inc >= eff_width;
   assign ocol_inc  = {1'b0, out_col_ff} + WIDTH_W'(1);
   assign ocol_wrap = ocol_inc >= eff_width;
   assign emit      = !((in_row_ff == '0) || ((in_row_ff == ROW_W'(1)) && (col_cur == '0)));
   assign last_hit  = {1'b0, out_count_ff} >= (total_ff - TOTAL_W'(1));
   assign interior  = (out_row_ff != '0)
                   && (out_row_ff < (CNT_W'(eff_height) - CNT_W'(1)))
                   && (out_col_ff != '0)
                   && ({1'b0, out_col_ff} < (eff_width - WIDTH_W'(1)));
   assign pixel_x   = (req_type == REQ_FLUSH) ? '0 : req_pixel_in;

   always_comb begin
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      out_count_in = out_count_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      if (div_st.done) begin
         out_row_in = div_st.quotient;
         out_col_in = div_st.remainder;
      end else if (req_accept) begin
         if (col_wrap) begin
            in_column_in = '0;
            if (in_row_ff != ROW_LIMIT) begin
               in_row_in = in_row_ff + ROW_W'(1);
            end
         end else begin
            in_column_in = col_inc[COL_W-1:0];
         end
         if (emit) begin
            if (last_hit) begin
               in_column_in = '0;
               in_row_in    = '0;
               out_count_in = '0;
               out_col_in   = '0;
               out_row_in   = '0;
            end else begin
               out_count_in = out_count_ff + CNT_W'(1);
               if (ocol_wrap) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + CNT_W'(1);
               end else begin
                  out_col_in = ocol_inc[COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         out_count_ff <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         out_count_ff <= out_count_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
      end
   end

   // stage one: line memory read returns, window shifts
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_emit_ff     <= emit;
         s1_interior_ff <= interior;
         s1_last_ff     <= last_hit;
         s1_col_ff      <= col_cur;
         s1_pixel_ff    <= pixel_x;
      end
   end

   lsh_line_store u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr   (col_cur),
      .wr_en     (s1_advance),
      .wr_addr   (s1_col_ff),
      .wr_upper  (mid),
      .wr_middle (s1_pixel_ff),
      .rd_upper  (top),
      .rd_middle (mid)
   );

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         win_mid1_ff <= win_mid2_ff;
         win_mid2_ff <= mid;
         win_top2_ff <= top;
         win_bot2_ff <= s1_pixel_ff;
      end
   end

   // kernel on the shifted window
   assign centre5   = {1'b0, win_mid2_ff, 2'b00} + 11'(win_mid2_ff);
   assign neigh_sum = 10'(win_mid1_ff) + 10'(mid) + 10'(win_top2_ff) + 10'(win_bot2_ff);
   assign sharp     = signed'({1'b0, centre5}) - signed'({2'b00, neigh_sum});

   always_comb begin
      if (sharp[11]) begin
         sharp_clamped = '0;
      end else if (sharp[10:8] != 3'b000) begin
         sharp_clamped = '1;
      end else begin
         sharp_clamped = sharp[7:0];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit_ff) begin
         rsp_pixel_ff <= s1_interior_ff ? sharp_clamped : '0;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

   // checks
   a_cfg_holds_input: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT))
      |=> !req_ready)
      else $error("word taken straight after a size write");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && last_hit)
      |=> (out_count_ff == '0 && in_row_ff == '0 && in_column_ff == '0))
      else $error("position not cleared after final pixel");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      !div_st.busy |-> ({1'b0, out_col_ff} < eff_width))
      else $error("output column beyond frame width");

endmodule

// ===== bench/laplacian_sharpen_3x3_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core_tb
// Self-checking bench for the streaming 3x3 cross-kernel sharpening core.
// ----------------------------------------------------------------------------
// Pixel words go in over the req_ channel. A behavioural line-store model of
// the filter predicts every sharpened word and its frame_last flag, and each
// word taken from the rsp_ channel is checked against the oldest prediction.
// Tests cover the reset frame size, clamping at both ends, tiny and saturated
// frame sizes, resizing in mid-frame, a long output stall and random frames.
// Both channels idle in random bursts; the tail of the run has no idling.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_core_tb;
   import lsh_pkg::*;

   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int REPORT_LIMIT    = 100;
   localparam int RANDOM_WORDS    = 200;
   localparam int QUIET_TAIL      = 80;

   localparam logic REQ_PIXEL = ~REQ_FLUSH;
   localparam csr_index_type CSR_SPARE_2 = csr_index_type'(2'd2);
   localparam csr_index_type CSR_SPARE_3 = csr_index_type'(2'd3);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } sharp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_frame_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // filter model state
   logic [WIDTH_W-1:0]  size_width  = RESET_WIDTH;
   logic [HEIGHT_W-1:0] size_height = RESET_HEIGHT;
   logic [PIX_W-1:0]    line_above [MAX_WIDTH];
   logic [PIX_W-1:0]    line_mid [MAX_WIDTH];
   logic [PIX_W-1:0]    win [3][3];
   int unsigned         pos_col   = 0;
   int unsigned         pos_row   = 0;
   int unsigned         out_index = 0;

   sharp_word_type sharpened_q [$];
   sharp_word_type due;

   int  error_count = 0;
   int  words_sent  = 0;
   int  cycle_count = 0;
   bit  gaps_on     = 1'b1;
   bit  hold_off_req = 1'b0;

   laplacian_sharpen_3x3_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_above[i] = '0;
         line_mid[i]   = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) win[r][k] = '0;
      end
   end

   // predicts the word, if any, that one accepted input word brings out
   task automatic sharpen_step(input logic kind, input logic [PIX_W-1:0] pix);
      int unsigned w, h, col, item, p, orow, ocol, total;
      logic [PIX_W-1:0] x, top, mid;
      int s;
      sharp_word_type r;
      w = (size_width == 0) ? 1 : ((size_width > MAX_WIDTH) ? MAX_WIDTH : size_width);
      h = (size_height == 0) ? 1 : ((size_height > MAX_HEIGHT) ? MAX_HEIGHT : size_height);
      x = (kind == REQ_FLUSH) ? '0 : pix;
      col = pos_col;
      if (col >= w) col = 0;
      item = pos_row * w + col;
      top = line_above[col];
      mid = line_mid[col];
      line_above[col] = mid;
      line_mid[col]   = x;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = x;
      col++;
      if (col >= w) begin
         col = 0;
         if (pos_row < ROW_LIMIT) pos_row++;
      end
      pos_col = col;
      if (item >= w + 1) begin
         p     = out_index;
         orow  = p / w;
         ocol  = p % w;
         total = w * h;
         r.last  = (p >= total - 1);
         r.pixel = '0;
         if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1) begin
            s = 5 * int'(win[1][1]) - int'(win[1][0]) - int'(win[1][2])
                - int'(win[0][1]) - int'(win[2][1]);
            r.pixel = (s < 0) ? 8'd0 : ((s > 255) ? 8'd255 : PIX_W'(s));
         end
         sharpened_q.push_back(r);
         if (r.last) begin
            out_index = 0;
            pos_col   = 0;
            pos_row   = 0;
         end else begin
            out_index = (p + 1) & 32'h7F_FFFF;
         end
      end
   endtask

   task automatic send_word(input logic kind, input logic [PIX_W-1:0] pix);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      sharpen_step(kind, pix);
      words_sent++;
   endtask

   task automatic send_pixels(input int unsigned count, input bit noisy);
      logic kind;
      for (int unsigned i = 0; i < count; i++) begin
         kind = (noisy && $urandom_range(0, 15) == 0) ? REQ_FLUSH : REQ_PIXEL;
         send_word(kind, PIX_W'($urandom_range(0, 255)));
      end
   endtask

   // flush words until the output frame closes
   task automatic finish_frame();
      while (!(pos_col == 0 && pos_row == 0 && out_index == 0))
         send_word(REQ_FLUSH, PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (sharpened_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (sharpened_q.size() != 0) begin
         error_count++;
         $error("%0d sharpened words never arrived", sharpened_q.size());
         sharpened_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_IMAGE_WIDTH:  size_width  = data[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: size_height = data[HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // reset width keeps the first row open, then a small frame takes over
   task automatic test_reset_sizes();
      send_pixels(100, 1'b0);
      wait_idle();
      configure(13'd4, 13'd3);
      send_pixels(12, 1'b0);
      finish_frame();
      wait_idle();
   endtask

   task automatic test_kernel_extremes();
      logic [8:0] pattern [16] = '{
         {REQ_PIXEL, 8'd0},   {REQ_PIXEL, 8'd255}, {REQ_PIXEL, 8'd0},  {REQ_PIXEL, 8'd255},
         {REQ_PIXEL, 8'd255}, {REQ_PIXEL, 8'd255}, {REQ_PIXEL, 8'd0},  {REQ_PIXEL, 8'd128},
         {REQ_PIXEL, 8'd0},   {REQ_FLUSH, 8'd255}, {REQ_PIXEL, 8'd60}, {REQ_PIXEL, 8'd255},
         {REQ_PIXEL, 8'd255}, {REQ_PIXEL, 8'd0},   {REQ_PIXEL, 8'd20}, {REQ_PIXEL, 8'd0}
      };
      configure(13'd4, 13'd4);
      foreach (pattern[i]) send_word(pattern[i][8], pattern[i][7:0]);
      finish_frame();
      wait_idle();
   endtask

   task automatic test_small_frames();
      int unsigned dims [5][2] = '{'{1, 1}, '{2, 2}, '{3, 3}, '{1, 5}, '{5, 1}};
      // width field wraps to zero, height zero
      configure(13'h1000, 13'h0000);
      send_pixels(1, 1'b0);
      finish_frame();
      wait_idle();
      foreach (dims[i]) begin
         configure(CSR_DATA_W'(dims[i][0]), CSR_DATA_W'(dims[i][1]));
         send_pixels(dims[i][0] * dims[i][1], 1'b0);
         finish_frame();
         wait_idle();
      end
      // unmapped indexes must leave the sizes alone
      write_reg(CSR_SPARE_2, 13'h0005);
      write_reg(CSR_SPARE_3, 13'h1FFF);
      csr_valid <= 1'b0;
      send_pixels(5, 1'b0);
      finish_frame();
      wait_idle();
   endtask

   task automatic test_mid_frame_resize();
      // height cut below the current output position
      configure(13'd8, 13'd8);
      send_pixels(48, 1'b0);
      wait_idle();
      write_reg(CSR_IMAGE_HEIGHT, 13'd3);
      csr_valid <= 1'b0;
      finish_frame();
      send_pixels(24, 1'b0);
      finish_frame();
      wait_idle();
      // narrower rows with the column past the new width
      configure(13'd10, 13'd10);
      send_pixels(38, 1'b0);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 13'd6);
      csr_valid <= 1'b0;
      send_pixels(24, 1'b0);
      finish_frame();
      wait_idle();
   endtask

   // both sizes beyond their bounds, then a 40-wide frame from column 0
   task automatic test_saturated_sizes();
      configure(13'h1FFF, 13'h1FFF);
      send_pixels(45, 1'b0);
      wait_idle();
      configure(13'd40, 13'd2);
      send_pixels(80, 1'b0);
      finish_frame();
      wait_idle();
   endtask

   task automatic test_output_stall();
      configure(13'd8, 13'd6);
      hold_off_req = 1'b1;
      send_pixels(48, 1'b1);
      finish_frame();
      wait_idle();
   endtask

   task automatic test_random_frames();
      int unsigned w, h, start;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         gaps_on = (words_sent - start < RANDOM_WORDS - QUIET_TAIL);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         wait_idle();
         configure(CSR_DATA_W'(w), CSR_DATA_W'(h));
         if ($urandom_range(0, 9) == 0) begin
            // cut short, the next frame size lands mid-frame
            send_pixels($urandom_range(1, w * h), 1'b1);
         end else begin
            send_pixels(w * h, 1'b1);
            finish_frame();
         end
      end
      gaps_on = 1'b0;
   endtask

   // result sink: random stalls, plus one long hold-off on request
   initial begin : sink_ctrl
      int n;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sharpened_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $error("unexpected word: pixel_out %0d frame_last %0b",
                      rsp_pixel_out, rsp_frame_last);
         end else begin
            due = sharpened_q.pop_front();
            if (rsp_pixel_out !== due.pixel) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("pixel_out: expected %0d, got %0d", due.pixel, rsp_pixel_out);
            end
            if (rsp_frame_last !== due.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("frame_last: expected %0b, got %0b", due.last, rsp_frame_last);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_kernel_extremes();
      test_small_frames();
      test_mid_frame_resize();
      test_saturated_sizes();
      test_output_stall();
      test_random_frames();
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
